@@ design/pru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg: permutation rank / unrank shared definitions
// Widths, factorial table and the small helpers used by the datapath stages.
// ----------------------------------------------------------------------------
package pru_pkg;

    // largest element count and field geometry
    localparam int MAX_ELEMS  = 8;
    localparam int NUM_FIELDS = 8;
    localparam int ELEM_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int RANK_W     = 16;
    localparam int FACT_W     = 17;
    localparam int REM6_W     = 10;
    localparam int REM3_W     = 3;
    localparam int NUM_STAGES = 6;

    // largest valid rank plus one (8!)
    localparam logic [FACT_W-1:0] RANK_LIMIT = 17'd40320;

    typedef logic [NUM_FIELDS-1:0][ELEM_W-1:0] t_elem_vec;
    typedef logic [RANK_W-1:0] t_rank_quad [4];
    typedef logic [RANK_W-1:0] t_rank_pair [2];

    // one factoradic digit and what is left of the value
    typedef struct packed {
        logic [ELEM_W-1:0] digit;
        logic [RANK_W-1:0] rest;
    } t_digit_split;

    // factorial lookup
    function automatic logic [FACT_W-1:0] fact_of(input logic [COUNT_W-1:0] n);
        logic [FACT_W-1:0] f;
        case (n)
            4'd0:    f = 17'd1;
            4'd1:    f = 17'd1;
            4'd2:    f = 17'd2;
            4'd3:    f = 17'd6;
            4'd4:    f = 17'd24;
            4'd5:    f = 17'd120;
            4'd6:    f = 17'd720;
            4'd7:    f = 17'd5040;
            default: f = RANK_LIMIT;
        endcase
        return f;
    endfunction

    // digit of v at weight w: a ladder of parallel compares, then one subtract
    function automatic t_digit_split split_digit(input logic [RANK_W-1:0] v,
                                                 input logic [RANK_W-1:0] w);
        t_digit_split res;
        logic [ELEM_W-1:0] d;
        logic [FACT_W-1:0] step;
        d = '0;
        for (int k = 1; k < NUM_FIELDS; k++) begin
            step = FACT_W'(k) * FACT_W'(w);
            if ({1'b0, v} >= step) d = ELEM_W'(k);
        end
        res.digit = d;
        res.rest  = v - RANK_W'(RANK_W'(d) * w);
        return res;
    endfunction

    // drop entry d from an ordered list, closing the gap
    function automatic t_elem_vec remove_at(input t_elem_vec l,
                                            input logic [ELEM_W-1:0] d);
        t_elem_vec res;
        res = l;
        for (int j = 0; j < NUM_FIELDS - 1; j++) begin
            if (ELEM_W'(j) >= d) res[j] = l[j+1];
        end
        return res;
    endfunction

endpackage

@@ design/permutation_rank_unrank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_rank_unrank: Lehmer code rank / unrank pipeline
// Ranks a permutation of up to eight elements or unranks a factorial-base
// rank back into one, in a six stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  input    | in        | i_valid / o_stall   | i_mode, i_count, i_in_rank,
//           |           |                     | i_in_elem_0..7
//  output   | out       | o_valid / i_stall   | o_out_rank, o_out_elem_0..7,
//           |           |                     | o_rank_error
//
//  one word enters per cycle while o_stall is low; results leave in the order their words came
//  the depth is set by the digit split ladders and the unused-list picks
//  a stall on the output freezes every stage at once; nothing is lost
//  reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module permutation_rank_unrank
    import pru_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [RANK_W-1:0]   i_in_rank,
    input  logic [ELEM_W-1:0]   i_in_elem_0,
    input  logic [ELEM_W-1:0]   i_in_elem_1,
    input  logic [ELEM_W-1:0]   i_in_elem_2,
    input  logic [ELEM_W-1:0]   i_in_elem_3,
    input  logic [ELEM_W-1:0]   i_in_elem_4,
    input  logic [ELEM_W-1:0]   i_in_elem_5,
    input  logic [ELEM_W-1:0]   i_in_elem_6,
    input  logic [ELEM_W-1:0]   i_in_elem_7,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [RANK_W-1:0]   o_out_rank,
    output logic [ELEM_W-1:0]   o_out_elem_0,
    output logic [ELEM_W-1:0]   o_out_elem_1,
    output logic [ELEM_W-1:0]   o_out_elem_2,
    output logic [ELEM_W-1:0]   o_out_elem_3,
    output logic [ELEM_W-1:0]   o_out_elem_4,
    output logic [ELEM_W-1:0]   o_out_elem_5,
    output logic [ELEM_W-1:0]   o_out_elem_6,
    output logic [ELEM_W-1:0]   o_out_elem_7,
    output logic                o_rank_error
);

    // pipeline control
    logic [NUM_STAGES-1:0] r_valid;
    logic                  w_adv;

    assign o_valid = r_valid[NUM_STAGES-1];
    assign o_stall = r_valid[NUM_STAGES-1] && i_stall;
    assign w_adv   = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[NUM_STAGES-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: count clamp, range check, rank digits
    // ------------------------------------------------------------------
    t_elem_vec             w_e0;
    logic [COUNT_W-1:0]    n_s1_n;
    logic                  n_s1_err;
    t_elem_vec             n_s1_d;

    logic                  r_s1_mode;
    logic [COUNT_W-1:0]    r_s1_n;
    logic                  r_s1_err;
    logic [RANK_W-1:0]     r_s1_rank;
    t_elem_vec             r_s1_d;

    assign w_e0 = {i_in_elem_7, i_in_elem_6, i_in_elem_5, i_in_elem_4,
                   i_in_elem_3, i_in_elem_2, i_in_elem_1, i_in_elem_0};

    assign n_s1_n   = (i_count > COUNT_W'(MAX_ELEMS)) ? COUNT_W'(MAX_ELEMS) : i_count;
    assign n_s1_err = i_mode && ({1'b0, i_in_rank} >= fact_of(n_s1_n));

    // count of later smaller elements at each position
    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            n_s1_d[i] = '0;
            for (int j = i + 1; j < NUM_FIELDS; j++) begin
                if ((COUNT_W'(j) < n_s1_n) && (w_e0[i] > w_e0[j])) begin
                    n_s1_d[i] = n_s1_d[i] + ELEM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mode <= i_mode;
            r_s1_n    <= n_s1_n;
            r_s1_err  <= n_s1_err;
            r_s1_rank <= i_in_rank;
            r_s1_d    <= n_s1_d;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: rank digits to factoradic order, or top two unrank digits
    // ------------------------------------------------------------------
    t_elem_vec             n_s2_fd;
    logic [REM6_W-1:0]     n_s2_rem;
    t_digit_split          w_sp7;
    t_digit_split          w_sp6;

    logic                  r_s2_mode;
    logic [COUNT_W-1:0]    r_s2_n;
    logic                  r_s2_err;
    t_elem_vec             r_s2_fd;
    logic [REM6_W-1:0]     r_s2_rem;

    assign w_sp7 = split_digit(r_s1_rank, RANK_W'(fact_of(COUNT_W'(7))));
    assign w_sp6 = split_digit(w_sp7.rest, RANK_W'(fact_of(COUNT_W'(6))));
    assign n_s2_rem = w_sp6.rest[REM6_W-1:0];

    always_comb begin
        logic [COUNT_W-1:0] idx;
        idx     = '0;
        n_s2_fd = '0;
        if (r_s1_mode) begin
            n_s2_fd[7] = w_sp7.digit;
            n_s2_fd[6] = w_sp6.digit;
        end else begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
                idx = r_s1_n - COUNT_W'(k + 1);
                if (COUNT_W'(k) < r_s1_n) n_s2_fd[k] = r_s1_d[idx[ELEM_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_mode <= r_s1_mode;
            r_s2_n    <= r_s1_n;
            r_s2_err  <= r_s1_err;
            r_s2_fd   <= n_s2_fd;
            r_s2_rem  <= n_s2_rem;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: weighted digit pairs, or unrank digits five to three
    // ------------------------------------------------------------------
    t_rank_quad            n_s3_sum;
    t_elem_vec             n_s3_fd;
    t_digit_split          w_sp5;
    t_digit_split          w_sp4;
    t_digit_split          w_sp3;

    logic                  r_s3_mode;
    logic [COUNT_W-1:0]    r_s3_n;
    logic                  r_s3_err;
    t_elem_vec             r_s3_fd;
    t_rank_quad            r_s3_sum;
    logic [REM3_W-1:0]     r_s3_rem;

    assign w_sp5 = split_digit(RANK_W'(r_s2_rem), RANK_W'(fact_of(COUNT_W'(5))));
    assign w_sp4 = split_digit(w_sp5.rest, RANK_W'(fact_of(COUNT_W'(4))));
    assign w_sp3 = split_digit(w_sp4.rest, RANK_W'(fact_of(COUNT_W'(3))));

    // each digit times its factorial weight, summed in pairs
    always_comb begin
        logic [RANK_W-1:0] t_lo;
        logic [RANK_W-1:0] t_hi;
        for (int p = 0; p < 4; p++) begin
            t_lo = RANK_W'(r_s2_fd[2*p]) * RANK_W'(fact_of(COUNT_W'(2*p)));
            t_hi = RANK_W'(r_s2_fd[2*p+1]) * RANK_W'(fact_of(COUNT_W'(2*p+1)));
            n_s3_sum[p] = t_lo + t_hi;
        end
    end

    always_comb begin
        n_s3_fd = r_s2_fd;
        if (r_s2_mode) begin
            n_s3_fd[5] = w_sp5.digit;
            n_s3_fd[4] = w_sp4.digit;
            n_s3_fd[3] = w_sp3.digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_mode <= r_s2_mode;
            r_s3_n    <= r_s2_n;
            r_s3_err  <= r_s2_err;
            r_s3_fd   <= n_s3_fd;
            r_s3_sum  <= n_s3_sum;
            r_s3_rem  <= w_sp3.rest[REM3_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: second adder level, last digits, digit per position
    // ------------------------------------------------------------------
    t_rank_pair            n_s4_sum;
    t_elem_vec             n_s4_dsel;

    logic                  r_s4_mode;
    logic [COUNT_W-1:0]    r_s4_n;
    logic                  r_s4_err;
    t_rank_pair            r_s4_sum;
    t_elem_vec             r_s4_dsel;

    assign n_s4_sum[0] = r_s3_sum[0] + r_s3_sum[1];
    assign n_s4_sum[1] = r_s3_sum[2] + r_s3_sum[3];

    always_comb begin
        t_elem_vec          fd;
        logic [ELEM_W-1:0]  c2;
        logic [COUNT_W-1:0] idx;
        fd = r_s3_fd;
        // remainder below six splits into weights two and one
        if (r_s3_rem >= REM3_W'(4)) begin
            c2 = ELEM_W'(2);
        end else if (r_s3_rem >= REM3_W'(2)) begin
            c2 = ELEM_W'(1);
        end else begin
            c2 = '0;
        end
        fd[2] = c2;
        fd[1] = ELEM_W'(r_s3_rem) - {c2[ELEM_W-2:0], 1'b0};
        fd[0] = '0;
        // position i takes the digit of weight (n-1-i)!
        n_s4_dsel = '0;
        for (int i = 0; i < NUM_FIELDS; i++) begin
            idx = r_s3_n - COUNT_W'(i + 1);
            if (COUNT_W'(i) < r_s3_n) n_s4_dsel[i] = fd[idx[ELEM_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_mode <= r_s3_mode;
            r_s4_n    <= r_s3_n;
            r_s4_err  <= r_s3_err;
            r_s4_sum  <= n_s4_sum;
            r_s4_dsel <= n_s4_dsel;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: final rank sum, picks for positions zero to three
    // ------------------------------------------------------------------
    t_elem_vec             n_s5_list;
    t_elem_vec             n_s5_pick;

    logic                  r_s5_mode;
    logic [COUNT_W-1:0]    r_s5_n;
    logic                  r_s5_err;
    logic [RANK_W-1:0]     r_s5_sum;
    t_elem_vec             r_s5_dsel;
    t_elem_vec             r_s5_list;
    t_elem_vec             r_s5_pick;

    always_comb begin
        t_elem_vec lst;
        for (int j = 0; j < NUM_FIELDS; j++) lst[j] = ELEM_W'(j);
        n_s5_pick = '0;
        for (int i = 0; i < NUM_FIELDS / 2; i++) begin
            n_s5_pick[i] = lst[r_s4_dsel[i]];
            lst = remove_at(lst, r_s4_dsel[i]);
        end
        n_s5_list = lst;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_mode <= r_s4_mode;
            r_s5_n    <= r_s4_n;
            r_s5_err  <= r_s4_err;
            r_s5_sum  <= r_s4_sum[0] + r_s4_sum[1];
            r_s5_dsel <= r_s4_dsel;
            r_s5_list <= n_s5_list;
            r_s5_pick <= n_s5_pick;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: picks for positions four to seven, output register
    // ------------------------------------------------------------------
    t_elem_vec             n_out_elem;
    logic [RANK_W-1:0]     n_out_rank;

    logic [RANK_W-1:0]     r_out_rank;
    t_elem_vec             r_out_elem;
    logic                  r_out_err;

    always_comb begin
        t_elem_vec lst;
        t_elem_vec pick;
        lst  = r_s5_list;
        pick = r_s5_pick;
        for (int i = NUM_FIELDS / 2; i < NUM_FIELDS; i++) begin
            pick[i] = lst[r_s5_dsel[i]];
            lst = remove_at(lst, r_s5_dsel[i]);
        end
        // elements only for a good unrank and only inside the count
        for (int i = 0; i < NUM_FIELDS; i++) begin
            if (r_s5_mode && !r_s5_err && (COUNT_W'(i) < r_s5_n)) begin
                n_out_elem[i] = pick[i];
            end else begin
                n_out_elem[i] = '0;
            end
        end
        n_out_rank = r_s5_mode ? '0 : r_s5_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rank <= n_out_rank;
            r_out_elem <= n_out_elem;
            r_out_err  <= r_s5_err;
        end
    end

    assign o_out_rank   = r_out_rank;
    assign o_out_elem_0 = r_out_elem[0];
    assign o_out_elem_1 = r_out_elem[1];
    assign o_out_elem_2 = r_out_elem[2];
    assign o_out_elem_3 = r_out_elem[3];
    assign o_out_elem_4 = r_out_elem[4];
    assign o_out_elem_5 = r_out_elem[5];
    assign o_out_elem_6 = r_out_elem[6];
    assign o_out_elem_7 = r_out_elem[7];
    assign o_rank_error = r_out_err;

`ifndef SYNTH
    // an error word carries no rank and no elements
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rank_error) |-> ((o_out_rank == '0) && (r_out_elem == '0)))
        else $error("rank error word with nonzero payload");

    // a nonzero rank only comes from rank mode, which has no elements
    a_rank_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out_rank != '0)) |-> (!o_rank_error && (r_out_elem == '0)))
        else $error("rank word mixed with unrank fields");

    // ranks always stay below eight factorial
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_out_rank} < RANK_LIMIT))
        else $error("rank out of range");

    // a stalled result is still there on the next cycle
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");
`endif

endmodule
